// ----- rtl/gdd_pkg.sv -----
`timescale 1ns / 1ps

package gdd_pkg;

  // Largest year accepted as valid.
  localparam int unsigned MAX_YEAR = 9999;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CAT_W   = 3;
  localparam int unsigned STAT_W  = 2;

  // Day numbers carry one more bit than the count so saturation can be seen.
  localparam int unsigned DN_W = COUNT_W + 1;

  // Quotient of a 14-bit year by 100: (y * 5243) >> 19 is exact below 43699.
  localparam int unsigned RECIP100   = 5243;
  localparam int unsigned RECIP_SH   = 19;
  localparam int unsigned RECIP_W    = 13;
  localparam int unsigned PROD_W     = YEAR_W + RECIP_W;
  localparam int unsigned Q100_W     = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CAT_W-1:0] CAT_SAME_DAY   = 3'd0;
  localparam logic [CAT_W-1:0] CAT_ONE_DAY    = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SAME_MONTH = 3'd2;
  localparam logic [CAT_W-1:0] CAT_SAME_YEAR  = 3'd3;
  localparam logic [CAT_W-1:0] CAT_OTHER      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ORDER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  target_year;
    logic [MONTH_W-1:0] target_month;
    logic [DAY_W-1:0]   target_day;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic [CAT_W-1:0]   category;
    logic [STAT_W-1:0]  status;
  } out_t;

  // Per-query flags handed from the date units to the compare stage.
  typedef struct packed {
    logic ok_start;
    logic ok_target;
    logic same_year;
    logic same_month;
  } cmp_flags_t;

  // Days before the first of the month in a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gdd_daynum.sv -----
`timescale 1ns / 1ps

// Two-stage date unit: year quotients by 100, then validity, leap and day number.
module gdd_daynum (
  input  logic                            clk,
  input  logic [gdd_pkg::YEAR_W-1:0]      year,
  input  logic [gdd_pkg::MONTH_W-1:0]     month,
  input  logic [gdd_pkg::DAY_W-1:0]       day,
  output logic [gdd_pkg::DN_W-1:0]        day_num,
  output logic                            date_ok
);

  logic [gdd_pkg::YEAR_W-1:0]  y_r;
  logic [gdd_pkg::MONTH_W-1:0] m_r;
  logic [gdd_pkg::DAY_W-1:0]   d_r;
  logic [gdd_pkg::Q100_W-1:0]  qy_r, qy_nxt;
  logic [gdd_pkg::Q100_W-1:0]  qp_r, qp_nxt;
  logic [gdd_pkg::DN_W-1:0]    dn_r, dn_nxt;
  logic                        ok_r, ok_nxt;

  logic [gdd_pkg::YEAR_W-1:0]  y_prev;
  logic [gdd_pkg::PROD_W-1:0]  prod_y, prod_p;
  logic [gdd_pkg::YEAR_W-1:0]  p;
  logic [gdd_pkg::YEAR_W:0]    qy_x100;
  logic                        div100, leap;
  logic [gdd_pkg::DAY_W-1:0]   dim;
  logic [gdd_pkg::DN_W-1:0]    cum;

  // Stage A: quotients of y and y-1 by 100.
  always_comb begin
    y_prev = year - gdd_pkg::YEAR_W'(1);
    prod_y = gdd_pkg::PROD_W'(year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP100);
    prod_p = gdd_pkg::PROD_W'(y_prev) * gdd_pkg::PROD_W'(gdd_pkg::RECIP100);
    qy_nxt = prod_y[gdd_pkg::RECIP_SH +: gdd_pkg::Q100_W];
    qp_nxt = prod_p[gdd_pkg::RECIP_SH +: gdd_pkg::Q100_W];
  end

  // Stage B: leap rule, range check, elapsed days since year 1, Jan 1.
  always_comb begin
    p       = y_r - gdd_pkg::YEAR_W'(1);
    qy_x100 = (gdd_pkg::YEAR_W+1)'(qy_r) * (gdd_pkg::YEAR_W+1)'(100);
    div100  = ({1'b0, y_r} == qy_x100);
    leap    = (y_r[1:0] == 2'b00) && (!div100 || (qy_r[1:0] == 2'b00));
    dim     = gdd_pkg::month_days(m_r, leap);
    ok_nxt  = (y_r != '0) && (32'(y_r) <= gdd_pkg::MAX_YEAR) &&
              (m_r >= 4'd1) && (m_r <= 4'd12) &&
              (d_r != '0) && (d_r <= dim);
    cum     = gdd_pkg::DN_W'(gdd_pkg::days_before(m_r)) +
              gdd_pkg::DN_W'(leap && (m_r > 4'd2));
    dn_nxt  = gdd_pkg::DN_W'(p) * gdd_pkg::DN_W'(365)
            + gdd_pkg::DN_W'(p >> 2)
            - gdd_pkg::DN_W'(qp_r)
            + gdd_pkg::DN_W'(qp_r >> 2)
            + cum
            + gdd_pkg::DN_W'(d_r) - gdd_pkg::DN_W'(1);
  end

  always_ff @(posedge clk) begin
    y_r  <= year;
    m_r  <= month;
    d_r  <= day;
    qy_r <= qy_nxt;
    qp_r <= qp_nxt;
    dn_r <= dn_nxt;
    ok_r <= ok_nxt;
  end

  assign day_num = dn_r;
  assign date_ok = ok_r;

endmodule

// ----- rtl/gdd_compare.sv -----
`timescale 1ns / 1ps

// Difference, order check, category and the result register.
module gdd_compare (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [gdd_pkg::DN_W-1:0]     dn_start,
  input  logic [gdd_pkg::DN_W-1:0]     dn_target,
  input  gdd_pkg::cmp_flags_t          flags,
  output logic                         res_valid,
  output gdd_pkg::out_t                res_data
);

  logic          valid_r;
  gdd_pkg::out_t data_r, data_nxt;
  logic [gdd_pkg::DN_W-1:0] diff;

  always_comb begin
    diff     = dn_target - dn_start;
    data_nxt = '0;
    if (!flags.ok_start || !flags.ok_target) begin
      data_nxt.status = gdd_pkg::ST_INVALID;
    end else if (dn_target < dn_start) begin
      data_nxt.status = gdd_pkg::ST_ORDER;
    end else begin
      data_nxt.status = gdd_pkg::ST_OK;
      if (diff > gdd_pkg::DN_W'(gdd_pkg::COUNT_MAX)) begin
        data_nxt.day_count = gdd_pkg::COUNT_MAX;
      end else begin
        data_nxt.day_count = diff[gdd_pkg::COUNT_W-1:0];
      end
      if (diff == '0) begin
        data_nxt.category = gdd_pkg::CAT_SAME_DAY;
      end else if (diff == gdd_pkg::DN_W'(1)) begin
        data_nxt.category = gdd_pkg::CAT_ONE_DAY;
      end else if (flags.same_month) begin
        data_nxt.category = gdd_pkg::CAT_SAME_MONTH;
      end else if (flags.same_year) begin
        data_nxt.category = gdd_pkg::CAT_SAME_YEAR;
      end else begin
        data_nxt.category = gdd_pkg::CAT_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    data_r <= data_nxt;
  end

  assign res_valid = valid_r;
  assign res_data  = data_r;

endmodule

// ----- rtl/gregorian_date_difference.sv -----
`timescale 1ns / 1ps

// Days between two Gregorian dates. A query is taken at every rising edge with
// start high; busy is always low, so one query can be issued every cycle. Each
// query gives exactly one result, shown on out_data for a single cycle with
// out_valid high. The strobe rises once the query has passed the input
// register, which loads at the edge that takes it, the two date-unit stages
// and the result register. The result is captured at the edge after the strobe
// rises. The receiver cannot stall: a result not captured in its cycle is gone.
// Results come out in query order. Status 2 flags an out-of-range field in
// either date, status 1 a target before the start; both return a count and
// category of zero.
module gregorian_date_difference (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gdd_pkg::in_t  in_data,
  output logic          out_valid,
  output gdd_pkg::out_t out_data
);

  // Input register: capture each query transfer.
  gdd_pkg::in_t in_r;
  logic         v0_r, v1_r, v2_r;
  logic         same_y_r, same_ym_r, same_y2_r, same_ym2_r;
  logic         same_y_nxt, same_ym_nxt;

  logic [gdd_pkg::DN_W-1:0] dn_start, dn_target;
  logic                     ok_start, ok_target;
  gdd_pkg::cmp_flags_t      flags;

  // Every stage advances each cycle; nothing ever holds a query off.
  assign busy = 1'b0;

  always_comb begin
    same_y_nxt  = (in_r.start_year == in_r.target_year);
    same_ym_nxt = same_y_nxt && (in_r.start_month == in_r.target_month);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    in_r       <= in_data;
    // Carry the year/month match flags alongside the date units.
    same_y_r   <= same_y_nxt;
    same_ym_r  <= same_ym_nxt;
    same_y2_r  <= same_y_r;
    same_ym2_r <= same_ym_r;
  end

  gdd_daynum u_start (
    .clk     (clk),
    .year    (in_r.start_year),
    .month   (in_r.start_month),
    .day     (in_r.start_day),
    .day_num (dn_start),
    .date_ok (ok_start)
  );

  gdd_daynum u_target (
    .clk     (clk),
    .year    (in_r.target_year),
    .month   (in_r.target_month),
    .day     (in_r.target_day),
    .day_num (dn_target),
    .date_ok (ok_target)
  );

  always_comb begin
    flags.ok_start   = ok_start;
    flags.ok_target  = ok_target;
    flags.same_year  = same_y2_r;
    flags.same_month = same_ym2_r;
  end

  // Subtract, classify and drive the one-cycle result strobe.
  gdd_compare u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .dn_start  (dn_start),
    .dn_target (dn_target),
    .flags     (flags),
    .res_valid (out_valid),
    .res_data  (out_data)
  );

endmodule

// ----- sim/tb_gregorian_date_difference.sv -----
`timescale 1ns / 1ps

// Checks the date difference block against a day-number predictor.
// Every query taken by the block is predicted at the edge that takes it; every
// out_valid strobe is compared with the oldest prediction. Stimulus runs from
// calendar corner cases through random bursts, a full drain and a
// back-to-back stretch.
module tb_gregorian_date_difference;
  import gdd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  // Predicted results in transfer order, oldest first.
  out_t diffs_due[$];
  int unsigned error_count = 0;

  // Sender pacing: queries left in the current burst, and whether gaps are off.
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;

  always #2 clk = ~clk;

  gregorian_date_difference u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = is_leap_year(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic bit date_ok(input int unsigned y, input int unsigned m,
                                 input int unsigned d);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  // Days elapsed since 0001-01-01; the date must be valid.
  function automatic longint unsigned serial_day(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
    longint unsigned p;
    longint unsigned n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  function automatic out_t predict_difference(input in_t q);
    out_t            r;
    longint unsigned from_day;
    longint unsigned to_day;
    longint unsigned span;
    r = '0;
    // Validity wins over ordering: a bad field anywhere is reported first.
    if (!date_ok(q.start_year, q.start_month, q.start_day) ||
        !date_ok(q.target_year, q.target_month, q.target_day)) begin
      r.status = ST_INVALID;
      return r;
    end
    from_day = serial_day(q.start_year, q.start_month, q.start_day);
    to_day   = serial_day(q.target_year, q.target_month, q.target_day);
    if (to_day < from_day) begin
      r.status = ST_ORDER;
      return r;
    end
    span = to_day - from_day;
    if (span == 0) r.category = CAT_SAME_DAY;
    else if (span == 1) r.category = CAT_ONE_DAY;
    else if (q.target_year == q.start_year && q.target_month == q.start_month)
      r.category = CAT_SAME_MONTH;
    else if (q.target_year == q.start_year) r.category = CAT_SAME_YEAR;
    else r.category = CAT_OTHER;
    r.day_count = (span > COUNT_MAX) ? COUNT_MAX : span[COUNT_W-1:0];
    r.status    = ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor: check each strobe first, then record the query taken at
  // this edge. The block's latency keeps the two from touching the same entry.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (diffs_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result with nothing due: count=%0d cat=%0d status=%0d",
                     $realtime, out_data.day_count, out_data.category, out_data.status);
        end else begin
          want = diffs_due.pop_front();
          if (out_data.day_count !== want.day_count || out_data.category !== want.category ||
              out_data.status !== want.status) begin
            error_count++;
            if (error_count <= 10)
              $display({"%0t: mismatch: expected count=%0d cat=%0d status=%0d, ",
                        "got count=%0d cat=%0d status=%0d"},
                       $realtime, want.day_count, want.category, want.status,
                       out_data.day_count, out_data.category, out_data.status);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) diffs_due.push_back(predict_difference(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one query and return on the edge that transfers it. Called and
  // returning just after a rising edge; start stays high for the next query.
  task automatic send_query(input in_t q);
    in_data <= q;
    start   <= 1'b1;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for an idle gap whose length is n; a zero n leaves start alone so
  // that it is never lowered and raised in the same step.
  task automatic hold_idle(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Bursts of random length with random gaps between them.
  task automatic send_paced(input in_t q);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        hold_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    send_query(q);
  endtask

  // Wait until every predicted result has been checked.
  task automatic drain_results();
    hold_idle(1);
    while (diffs_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Query builders
  // ---------------------------------------------------------------------------

  function automatic in_t date_pair(input int unsigned sy, input int unsigned sm,
                                    input int unsigned sd, input int unsigned ty,
                                    input int unsigned tm, input int unsigned td);
    in_t q;
    q.start_year   = sy[YEAR_W-1:0];
    q.start_month  = sm[MONTH_W-1:0];
    q.start_day    = sd[DAY_W-1:0];
    q.target_year  = ty[YEAR_W-1:0];
    q.target_month = tm[MONTH_W-1:0];
    q.target_day   = td[DAY_W-1:0];
    return q;
  endfunction

  // Valid date, biased toward century years and month ends.
  task automatic pick_valid_date(output int unsigned y, output int unsigned m,
                                 output int unsigned d);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       y = 1;
      1:       y = MAX_YEAR;
      2:       y = 100 * $urandom_range(1, MAX_YEAR / 100);
      3:       y = 4 * $urandom_range(1, MAX_YEAR / 4);
      default: y = $urandom_range(1, MAX_YEAR);
    endcase
    m = $urandom_range(1, 12);
    if ($urandom_range(0, 4) == 0) d = month_length(y, m);
    else d = $urandom_range(1, month_length(y, m));
  endtask

  task automatic step_one_day(inout int unsigned y, inout int unsigned m,
                              inout int unsigned d);
    if (d < month_length(y, m)) d++;
    else if (m < 12) begin
      m++;
      d = 1;
    end else if (y < MAX_YEAR) begin
      y++;
      m = 1;
      d = 1;
    end
  endtask

  // Push one field out of range; the other five stay valid.
  task automatic break_one_field(inout in_t q);
    int unsigned len;
    case ($urandom_range(0, 5))
      0, 3: begin
        if ($urandom_range(0, 1) == 0 || MAX_YEAR >= (1 << YEAR_W) - 1) begin
          if ($urandom_range(0, 1) == 0) q.start_year = '0;
          else q.target_year = '0;
        end else begin
          if ($urandom_range(0, 1) == 0)
            q.start_year = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
          else
            q.target_year = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
        end
      end
      1, 4: begin
        if ($urandom_range(0, 1) == 0)
          q.start_month = MONTH_W'(($urandom_range(0, 1) == 0) ? 0
                                   : $urandom_range(13, 15));
        else
          q.target_month = MONTH_W'(($urandom_range(0, 1) == 0) ? 0
                                    : $urandom_range(13, 15));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          len = month_length(q.start_year, q.start_month);
          q.start_day = DAY_W'((len == 31 || $urandom_range(0, 2) == 0) ? 0
                               : $urandom_range(len + 1, 31));
        end else begin
          len = month_length(q.target_year, q.target_month);
          q.target_day = DAY_W'((len == 31 || $urandom_range(0, 2) == 0) ? 0
                                : $urandom_range(len + 1, 31));
        end
      end
    endcase
  endtask

  // Mostly well-formed pairs spread over every category, then broken fields,
  // reversed pairs and raw noise.
  task automatic random_query(output in_t q);
    int unsigned     kind;
    int unsigned     sy, sm, sd, ty, tm, td;
    logic [63:0]     noise;
    kind = $urandom_range(0, 99);
    pick_valid_date(sy, sm, sd);
    ty = sy;
    tm = sm;
    td = sd;
    if (kind < 8) begin
      // same date
    end else if (kind < 20) begin
      step_one_day(ty, tm, td);
    end else if (kind < 32) begin
      td = $urandom_range(1, month_length(ty, tm));
    end else if (kind < 44) begin
      tm = $urandom_range(1, 12);
      td = $urandom_range(1, month_length(ty, tm));
    end else if (kind < 80) begin
      if (kind < 56) ty = (sy + $urandom_range(0, 5) > MAX_YEAR) ? MAX_YEAR
                        : sy + $urandom_range(0, 5);
      else pick_valid_date(ty, tm, td);
      tm = (kind < 56) ? $urandom_range(1, 12) : tm;
      td = (kind < 56) ? $urandom_range(1, month_length(ty, tm)) : td;
      // Most pairs in order; the rest stay as drawn and may be reversed.
      if (kind < 72 && serial_day(ty, tm, td) < serial_day(sy, sm, sd)) begin
        q = date_pair(ty, tm, td, sy, sm, sd);
        return;
      end
    end else if (kind < 92) begin
      q = date_pair(sy, sm, sd, ty, tm, td);
      break_one_field(q);
      return;
    end else begin
      noise = {$urandom(), $urandom()};
      q = noise[$bits(in_t)-1:0];
      return;
    end
    q = date_pair(sy, sm, sd, ty, tm, td);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_calendar_edges();
    send_paced(date_pair(1, 1, 1, 1, 1, 1));              // same day, lowest date
    send_paced(date_pair(1, 1, 1, MAX_YEAR, 12, 31));     // widest span
    send_paced(date_pair(MAX_YEAR, 12, 31, MAX_YEAR, 12, 31));
    send_paced(date_pair(2000, 2, 28, 2000, 2, 29));      // leap by 400
    send_paced(date_pair(1900, 2, 28, 1900, 3, 1));       // century, not leap
    send_paced(date_pair(1900, 2, 29, 1900, 3, 1));       // no Feb 29 in 1900
    send_paced(date_pair(2100, 2, 1, 2100, 2, 29));
    send_paced(date_pair(2400, 2, 29, 2401, 3, 1));
    send_paced(date_pair(2024, 12, 31, 2025, 1, 1));      // one day across years
    send_paced(date_pair(1999, 12, 31, 2000, 1, 1));
    send_paced(date_pair(2023, 5, 3, 2023, 5, 30));       // same month
    send_paced(date_pair(2023, 1, 31, 2023, 12, 1));      // same year
    send_paced(date_pair(2023, 5, 4, 2023, 5, 3));        // target before start
    send_paced(date_pair(9000, 1, 1, 8191, 12, 31));
    send_paced(date_pair(0, 1, 1, 2000, 1, 1));           // year zero
    send_paced(date_pair(2000, 1, 1, MAX_YEAR + 1, 1, 1));
    send_paced(date_pair(16383, 15, 31, 16383, 15, 31));  // every bit high
    send_paced(date_pair(2000, 0, 1, 2000, 13, 1));       // bad months
    send_paced(date_pair(2000, 1, 0, 2000, 4, 31));       // bad days
    send_paced(date_pair(2023, 4, 31, 2000, 1, 1));       // bad field and reversed
    send_paced(date_pair(0, 0, 0, 0, 0, 0));
    send_paced(date_pair(8192, 8, 16, 8192, 8, 17));
  endtask

  task automatic test_random_bursts(input int unsigned n);
    in_t q;
    for (int unsigned i = 0; i < n; i++) begin
      random_query(q);
      send_paced(q);
    end
  endtask

  // Pause until the pipe is empty, then resume at once.
  task automatic test_drain_and_resume(input int unsigned n);
    test_random_bursts(n);
    drain_results();
    test_random_bursts(n);
  endtask

  // One query per cycle with no gaps at all.
  task automatic test_back_to_back(input int unsigned n);
    no_gaps = 1'b1;
    test_random_bursts(n);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_calendar_edges();
    test_random_bursts(700);
    test_drain_and_resume(150);
    test_back_to_back(500);
    test_random_bursts(500);
    drain_results();
    // Extra cycles catch any stray strobe after the last result.
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- gregorian_date_difference.f -----
rtl/gdd_pkg.sv
rtl/gdd_daynum.sv
rtl/gdd_compare.sv
rtl/gregorian_date_difference.sv
sim/tb_gregorian_date_difference.sv
